FILE: rtl/assert_macros.svh
// Assertion macros for the port-level checker module kvpd_checker.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KVPD_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KVPD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: rtl/kvpd_pkg.sv
// Shared types for the key=value percent-decode parser.
// Result kinds, error codes and the result word; no dependencies.
package kvpd_pkg;

   localparam int RES_MAX = 3;

   typedef enum logic [2:0] {
      KIND_KEY       = 3'd0,
      KIND_VALUE     = 3'd1,
      KIND_FIELD_END = 3'd2,
      KIND_ACCEPT    = 3'd3,
      KIND_REJECT    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_NO_EQUALS  = 2'd1,
      ERR_EMPTY_KEY  = 2'd2,
      ERR_BAD_ESCAPE = 2'd3
   } err_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      err_type    err;
      logic       last;
   } result_type;

endpackage

FILE: rtl/kvpd_parse.sv
// Byte classifier and token state for the key=value parser.
// Produces up to three result words per byte; depends on kvpd_pkg.
module kvpd_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_message,
   output logic [1:0]           res_count,
   output kvpd_pkg::result_type res_word [kvpd_pkg::RES_MAX]
);
   import kvpd_pkg::*;

   localparam logic [7:0] SEP_CHAR = 8'h3B;
   localparam logic [7:0] EQ_CHAR  = 8'h3D;
   localparam logic [7:0] PCT_CHAR = 8'h25;

   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_HIGH = 2'd1;
   localparam logic [1:0] ESC_LOW  = 2'd2;

   typedef struct packed {
      logic       in_value;
      logic       token_started;
      logic       key_nonempty;
      logic [1:0] escape_phase;
      logic [3:0] high_nibble;
      logic       message_failed;
   } state_type;

   // bit 4 set means not a hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
      return r;
   endfunction

   function automatic err_type token_end_error(input state_type s);
      err_type e;
      e = ERR_NONE;
      if (!s.in_value) e = ERR_NO_EQUALS;
      else if (s.escape_phase != ESC_NONE) e = ERR_BAD_ESCAPE;
      return e;
   endfunction

   state_type  state_ff;
   state_type  state_in;
   logic [4:0] hex;
   logic [1:0] n;
   err_type    err;

   assign hex = hex_decode(in_byte);

   always_comb begin
      state_in = state_ff;
      n        = 2'd0;
      err      = ERR_NONE;
      for (int i = 0; i < RES_MAX; i++) res_word[i] = '0;

      if (state_ff.message_failed) begin
         // drop everything up to the end of the failed message
         if (end_of_message) state_in = '0;
      end else begin
         if (in_byte == SEP_CHAR) begin
            if (state_ff.token_started) begin
               err = token_end_error(state_in);
               if (err == ERR_NONE) begin
                  res_word[n] = '{KIND_FIELD_END, 8'h00, ERR_NONE, 1'b0};
                  n = n + 2'd1;
               end
               state_in = '0;
            end
         end else begin
            state_in.token_started = 1'b1;
            if (!state_ff.in_value) begin
               if (in_byte == EQ_CHAR) begin
                  if (!state_ff.key_nonempty) err = ERR_EMPTY_KEY;
                  else state_in.in_value = 1'b1;
               end else begin
                  res_word[n] = '{KIND_KEY, in_byte, ERR_NONE, 1'b0};
                  n = n + 2'd1;
                  state_in.key_nonempty = 1'b1;
               end
            end else if (state_ff.escape_phase == ESC_HIGH) begin
               if (hex[4]) err = ERR_BAD_ESCAPE;
               else begin
                  state_in.high_nibble  = hex[3:0];
                  state_in.escape_phase = ESC_LOW;
               end
            end else if (state_ff.escape_phase == ESC_LOW) begin
               if (hex[4]) err = ERR_BAD_ESCAPE;
               else begin
                  res_word[n] = '{KIND_VALUE, {state_ff.high_nibble, hex[3:0]},
                                  ERR_NONE, 1'b0};
                  n = n + 2'd1;
                  state_in.escape_phase = ESC_NONE;
                  state_in.high_nibble  = 4'h0;
               end
            end else if (in_byte == PCT_CHAR) begin
               state_in.escape_phase = ESC_HIGH;
            end else begin
               res_word[n] = '{KIND_VALUE, in_byte, ERR_NONE, 1'b0};
               n = n + 2'd1;
            end
         end

         if (err == ERR_NONE && end_of_message) begin
            if (state_in.token_started) begin
               err = token_end_error(state_in);
               if (err == ERR_NONE) begin
                  res_word[n] = '{KIND_FIELD_END, 8'h00, ERR_NONE, 1'b0};
                  n = n + 2'd1;
               end
            end
            if (err == ERR_NONE) begin
               res_word[n] = '{KIND_ACCEPT, 8'h00, ERR_NONE, 1'b0};
               n = n + 2'd1;
            end
            state_in = '0;
         end

         if (err != ERR_NONE) begin
            res_word[n] = '{KIND_REJECT, 8'h00, err, 1'b0};
            n = n + 2'd1;
            state_in = '0;
            state_in.message_failed = !end_of_message;
         end
      end

      if (n != 2'd0) res_word[n - 2'd1].last = 1'b1;
   end

   assign res_count = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/kvpd_rsp_fifo.sv
// Four-word result queue taking up to three words per cycle, one out.
// Depends on kvpd_pkg for the result word.
module kvpd_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  kvpd_pkg::result_type push_word [kvpd_pkg::RES_MAX],
   input  logic                 pop,
   output kvpd_pkg::result_type head,
   output logic                 not_empty,
   output logic                 has_room
);
   import kvpd_pkg::*;

   localparam int DEPTH = 4;

   result_type  entry_ff [DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff,  count_in;
   logic        pop_ok;

   assign not_empty = (count_ff != 3'd0);
   assign pop_ok    = pop && not_empty;
   // room for a full burst of results
   assign has_room  = (count_ff <= 3'(DEPTH - RES_MAX));
   assign head      = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + push_count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop_ok};
   assign count_in  = count_ff + {1'b0, push_count} - {2'b00, pop_ok};

   always_ff @(posedge clock) begin
      for (int i = 0; i < RES_MAX; i++) begin
         if (2'(i) < push_count) entry_ff[wr_ptr_ff + 2'(i)] <= push_word[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/key_value_percent_decode_parser.sv
// Streaming key=value parser with percent-decoding of values.
// Top level: instantiates kvpd_parse and kvpd_rsp_fifo; depends on kvpd_pkg.
//
// Usage:
//   req_* carries one message byte per word; req_end_of_message marks the final
//   byte. A word is taken when req_valid is high and req_stall is low.
//   rsp_* carries one result word per handshake: a key byte, a decoded value
//   byte, a field end, message accepted, or rejected with an error code.
//   rsp_last_of_run flags the last result word caused by one input byte.
// Results: each byte's result words are registered into the result queue and
//   reach rsp_* behind any words already waiting there.
// Throughput: one byte per cycle while rsp_stall is low and each byte yields
//   at most one result word; the four-word result queue is the limit, since a
//   byte is taken only when at least three free slots remain, so a byte with
//   two or three results holds the input until the queue drains to one word.
// Reset: synchronous, clears the token state and empties the result queue.
// Stall: while rsp_stall is high the head result holds; the queue fills and
//   req_stall rises once fewer than three slots are free.
module key_value_percent_decode_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last_of_run
);
   import kvpd_pkg::*;

   logic       req_accept;
   logic       has_room;
   logic [1:0] res_count;
   logic [1:0] push_count;
   result_type res_word [RES_MAX];
   result_type head;

   // take a byte only when the queue can absorb its worst-case burst
   assign req_stall  = !has_room;
   assign req_accept = req_valid && has_room;
   assign push_count = req_accept ? res_count : 2'd0;

   // classify the byte and advance the token state on accept
   kvpd_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .advance        (req_accept),
      .in_byte        (req_in_byte),
      .end_of_message (req_end_of_message),
      .res_count      (res_count),
      .res_word       (res_word)
   );

   // hold result words until the receiver takes them
   kvpd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_word  (res_word),
      .pop        (!rsp_stall),
      .head       (head),
      .not_empty  (rsp_valid),
      .has_room   (has_room)
   );

   assign rsp_result_kind = head.kind;
   assign rsp_data_byte   = head.data;
   assign rsp_error_code  = head.err;
   assign rsp_last_of_run = head.last;

endmodule

FILE: rtl/kvpd_checker.sv
// Port-level checks for the key=value parser, bound to the top level.
// Depends on kvpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_result_kind,
   input logic [7:0] rsp_data_byte,
   input logic [1:0] rsp_error_code,
   input logic       rsp_last_of_run
);
   import kvpd_pkg::*;

   `KVPD_ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)
   `KVPD_ASSERT_NEXT(a_rsp_hold_word, rsp_valid && rsp_stall, $stable(rsp_result_kind) && $stable(rsp_data_byte) && $stable(rsp_error_code) && $stable(rsp_last_of_run))
   `KVPD_ASSERT_NOW(a_err_only_reject, rsp_valid && rsp_result_kind != KIND_REJECT, rsp_error_code == ERR_NONE)
   `KVPD_ASSERT_NOW(a_ctrl_no_data, rsp_valid && (rsp_result_kind == KIND_FIELD_END || rsp_result_kind == KIND_ACCEPT || rsp_result_kind == KIND_REJECT), rsp_data_byte == 8'h00)
   `KVPD_ASSERT_NOW(a_verdict_last, rsp_valid && (rsp_result_kind == KIND_ACCEPT || rsp_result_kind == KIND_REJECT), rsp_last_of_run)

endmodule

bind key_value_percent_decode_parser kvpd_checker u_kvpd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_error_code  (rsp_error_code),
   .rsp_last_of_run (rsp_last_of_run)
);

FILE: tb/sv/kvpd_result_checker.sv
// Result checker for the key=value percent-decode parser.
// Watches the req_ and rsp_ channels, predicts every result word from the bytes
// taken, and compares in order; depends on kvpd_pkg.
module kvpd_result_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_message,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_result_kind,
   input  logic [7:0] rsp_data_byte,
   input  logic [1:0] rsp_error_code,
   input  logic       rsp_last_of_run,
   output int         mismatch_count,
   output int         pending_words,
   output int         bytes_taken,
   output int         words_checked,
   output int         accept_count,
   output int         reject_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import kvpd_pkg::*;

   localparam logic [7:0] SEP = 8'h3B;
   localparam logic [7:0] EQ  = 8'h3D;
   localparam logic [7:0] PCT = 8'h25;

   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_HIGH = 2'd1;
   localparam logic [1:0] ESC_LOW  = 2'd2;

   // Parser state as seen from outside.
   logic       in_value      = 1'b0;
   logic       token_open    = 1'b0;
   logic       key_seen      = 1'b0;
   logic [1:0] esc_phase     = ESC_NONE;
   logic [3:0] esc_high      = 4'd0;
   logic       msg_dead      = 1'b0;

   result_type expected_words[$];
   result_type step_words[$];

   // Value of a hex digit, or 16 when the byte is not one.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
      return 5'd16;
   endfunction

   function automatic err_type token_close_error();
      if (!in_value) return ERR_NO_EQUALS;
      if (esc_phase != ESC_NONE) return ERR_BAD_ESCAPE;
      return ERR_NONE;
   endfunction

   function automatic void add_word(input kind_type k, input logic [7:0] d, input err_type e);
      result_type w;
      w.kind = k;
      w.data = d;
      w.err  = e;
      w.last = 1'b0;
      step_words = {step_words, w};
   endfunction

   function automatic void clear_token();
      in_value   = 1'b0;
      token_open = 1'b0;
      key_seen   = 1'b0;
      esc_phase  = ESC_NONE;
      esc_high   = 4'd0;
   endfunction

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH at %0t: %s", $time, msg);
   endfunction

   // Work out the result words caused by one byte and queue them.
   function automatic void decode_byte(input logic [7:0] b, input logic eom);
      err_type    err;
      logic [4:0] nib;
      err = ERR_NONE;
      nib = hex_nibble(b);
      step_words.delete();

      // Drop the rest of a rejected message; its final byte clears everything.
      if (msg_dead) begin
         if (eom) begin
            clear_token();
            msg_dead = 1'b0;
         end
         return;
      end

      if (b == SEP) begin
         if (token_open) begin
            err = token_close_error();
            if (err == ERR_NONE) add_word(KIND_FIELD_END, 8'd0, ERR_NONE);
            clear_token();
         end
      end else begin
         token_open = 1'b1;
         if (!in_value) begin
            if (b == EQ) begin
               if (!key_seen) err = ERR_EMPTY_KEY;
               else in_value = 1'b1;
            end else begin
               add_word(KIND_KEY, b, ERR_NONE);
               key_seen = 1'b1;
            end
         end else if (esc_phase != ESC_NONE) begin
            if (nib[4]) begin
               err = ERR_BAD_ESCAPE;
            end else if (esc_phase == ESC_HIGH) begin
               esc_high  = nib[3:0];
               esc_phase = ESC_LOW;
            end else begin
               add_word(KIND_VALUE, {esc_high, nib[3:0]}, ERR_NONE);
               esc_phase = ESC_NONE;
               esc_high  = 4'd0;
            end
         end else if (b == PCT) begin
            esc_phase = ESC_HIGH;
         end else begin
            add_word(KIND_VALUE, b, ERR_NONE);
         end
      end

      if (err == ERR_NONE && eom) begin
         if (token_open) begin
            err = token_close_error();
            if (err == ERR_NONE) add_word(KIND_FIELD_END, 8'd0, ERR_NONE);
         end
         if (err == ERR_NONE) begin
            add_word(KIND_ACCEPT, 8'd0, ERR_NONE);
            accept_count++;
         end
         clear_token();
         msg_dead = 1'b0;
      end

      if (err != ERR_NONE) begin
         add_word(KIND_REJECT, 8'd0, err);
         reject_count++;
         clear_token();
         msg_dead = !eom;
      end

      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      expected_words = {expected_words, step_words};
   endfunction

   always @(posedge clock) begin : watch
      result_type exp_word;
      if (reset) begin
         clear_token();
         msg_dead = 1'b0;
         expected_words.delete();
      end else begin
         // A byte's results are registered in the queue before they show, so check first.
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               note_failure($sformatf("unexpected word kind %0d data %02h err %0d last %0b",
                  rsp_result_kind, rsp_data_byte, rsp_error_code, rsp_last_of_run));
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_result_kind !== exp_word.kind || rsp_data_byte !== exp_word.data ||
                   rsp_error_code !== exp_word.err || rsp_last_of_run !== exp_word.last)
                  note_failure($sformatf(
                     "expected kind %0d data %02h err %0d last %0b, got %0d %02h %0d %0b",
                     exp_word.kind, exp_word.data, exp_word.err, exp_word.last,
                     rsp_result_kind, rsp_data_byte, rsp_error_code, rsp_last_of_run));
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            decode_byte(req_in_byte, req_end_of_message);
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

FILE: tb/sv/tb_key_value_percent_decode_parser.sv
// Testbench top for key_value_percent_decode_parser.
// Drives message bytes and result stalls, and gives the verdict; prediction and
// comparison live in kvpd_result_checker. Depends on kvpd_pkg and the RTL.
module tb_key_value_percent_decode_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] SEP = 8'h3B;
   localparam logic [7:0] EQ  = 8'h3D;
   localparam logic [7:0] PCT = 8'h25;

   // Every block input starts at a known value.
   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic [7:0] req_in_byte        = 8'd0;
   logic       req_end_of_message = 1'b0;
   logic       rsp_stall          = 1'b0;

   logic       req_stall;
   logic       rsp_valid;
   logic [2:0] rsp_result_kind;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_error_code;
   logic       rsp_last_of_run;

   int mismatch_count;
   int pending_words;
   int bytes_taken;
   int words_checked;
   int accept_count;
   int reject_count;

   // Idle and stall odds, in percent, for the current phase.
   int idle_pct   = 0;
   int stall_pct  = 0;
   int bytes_sent = 0;

   // Bytes of the message about to be sent; the last one carries end_of_message.
   logic [7:0] msg_q[$];

   key_value_percent_decode_parser dut (.*);

   kvpd_result_checker checker_i (.*);

   always #5 clock = ~clock;

   // Stall the result side at random; stall_pct of zero gives a clean stretch.
   always @(posedge clock) rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

   // Hard stop far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [7:0] hex_char();
      int r;
      r = $urandom_range(21);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 16) return 8'(8'h41 + r - 10);
      return 8'(8'h61 + r - 16);
   endfunction

   // Pick a byte that keeps a token well formed: no separator, no '=' in a
   // key, no '%' in a value (escapes are built on purpose instead).
   function automatic logic [7:0] plain_byte(input logic in_key);
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == SEP || (in_key && b == EQ) || (!in_key && b == PCT));
      return b;
   endfunction

   // Bytes that steer the parser: separators, '=', '%', hex digits, anything.
   function automatic logic [7:0] tricky_byte();
      case ($urandom_range(4))
         0: return SEP;
         1: return EQ;
         2: return PCT;
         3: return hex_char();
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Add one byte to the end of the message being built.
   function automatic void append_byte(input logic [7:0] b);
      msg_q = {msg_q, b};
   endfunction

   // Build the next random message. Most are well-formed key=value lists with
   // random content; some get one byte swapped for a tricky one, the rest are
   // pure noise.
   task automatic build_random_message();
      int roll;
      int fields;
      int idx;
      roll = $urandom_range(99);
      msg_q.delete();
      if (roll < 80) begin
         if ($urandom_range(4) == 0) append_byte(SEP);
         fields = $urandom_range(1, 3);
         for (int f = 0; f < fields; f++) begin
            if (f > 0) repeat ($urandom_range(1, 2)) append_byte(SEP);
            repeat ($urandom_range(1, 3)) append_byte(plain_byte(1'b1));
            append_byte(EQ);
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(2) == 0) begin
                  append_byte(PCT);
                  append_byte(hex_char());
                  append_byte(hex_char());
               end else begin
                  append_byte(plain_byte(1'b0));
               end
            end
         end
         if ($urandom_range(3) == 0) append_byte(SEP);
         // Break a share of the good messages at one random spot.
         if (roll >= 65) begin
            idx = $urandom_range(msg_q.size() - 1);
            msg_q[idx] = tricky_byte();
         end
      end else begin
         repeat ($urandom_range(1, 10)) append_byte(tricky_byte());
      end
   endtask

   // Send msg_q one word per handshake. Hold each word until taken; drop valid
   // for random gaps between words as the phase asks.
   task automatic send_message();
      for (int i = 0; i < msg_q.size(); i++) begin
         while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid          <= 1'b1;
         req_in_byte        <= msg_q[i];
         req_end_of_message <= (i == msg_q.size() - 1);
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
   endtask

   // Hold off the sender until every predicted word has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Only separators: empty tokens are skipped and the message is accepted.
      msg_q = '{SEP, SEP};
      send_message();
      // Extreme bytes in key and value, '%' inside a key, a later '=' kept as a
      // value byte, and a mixed-case escape decoding to 0xFF.
      msg_q = '{8'hFF, PCT, EQ, 8'h00, EQ, PCT, "f", "F"};
      send_message();
      // Empty value closed by a separator, then an empty key; the trailing
      // byte is discarded and its end_of_message clears the state.
      msg_q = '{"k", EQ, SEP, EQ, "y"};
      send_message();
      // Missing equals, found on the final byte.
      msg_q = '{"a"};
      send_message();
      // Separator inside an escape, then a discarded final byte.
      msg_q = '{"b", EQ, PCT, "1", SEP, "q"};
      send_message();
      // Message ends with an escape still pending.
      msg_q = '{"c", EQ, PCT};
      send_message();
      wait_drain();

      // Four mixes: clean, sender gaps, receiver stalls, both a little.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 50; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 50; end
            default: begin idle_pct = 12; stall_pct <= 12; end
         endcase
         while (bytes_sent < 25 + 77 * (phase + 1)) begin
            build_random_message();
            send_message();
         end
         wait_drain();
      end

      // Let any stray word surface before the verdict.
      repeat (8) @(posedge clock);

      $display("Run covered %0d bytes and %0d result words: %0d messages accepted, %0d rejected.",
         bytes_taken, words_checked, accept_count, reject_count);
      $display("Phases: no idling, sender gaps, receiver stalls, and both mixed.");
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: key_value_percent_decode_parser.f
+incdir+rtl
rtl/kvpd_pkg.sv
rtl/kvpd_parse.sv
rtl/kvpd_rsp_fifo.sv
rtl/key_value_percent_decode_parser.sv
rtl/kvpd_checker.sv
tb/sv/kvpd_result_checker.sv
tb/sv/tb_key_value_percent_decode_parser.sv
